### rtl/bdq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the bounded deque.
package bdq_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam int OCC_W  = 5;
    localparam int CMD_W  = 2;
    localparam int STS_W  = 2;

    // Request kinds
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd3;

    // Result status codes
    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;

    // Reset value of the capacity register
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [0:0] {
        S_IDLE,
        S_READ
    } bdq_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // take the request on the input channel
        logic load_now;   // fill the result register from the request itself
        logic load_ram;   // fill the result register from the storage read
    } bdq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic needs_read; // request is a pop that finds an entry
    } bdq_status_t;

endpackage

### rtl/bdq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/bdq_ctrl.sv
`timescale 1ns / 1ps
// Controller of the bounded deque: request sequencing and result valid.
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  bdq_status_t dp_status,
    output bdq_cmd_t    dp_cmd
);

    bdq_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    // State and result valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result slot is free, or is emptied at this edge
    assign slot_free = !out_valid_reg || !out_stall;

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        dp_cmd          = '0;
        in_stall        = 1'b1;
        out_valid_next  = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = !slot_free;
                if (in_valid && slot_free)
                begin
                    dp_cmd.accept = 1'b1;
                    if (dp_status.needs_read)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        dp_cmd.load_now = 1'b1;
                        out_valid_next  = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                // slot was freed on entry and stays free until this load
                dp_cmd.load_ram = 1'b1;
                out_valid_next  = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/bdq_datapath.sv
`timescale 1ns / 1ps
// Datapath of the bounded deque: pointers, count, storage and result register.
module bdq_datapath
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bdq_cmd_t                 dp_cmd,
    output bdq_status_t              dp_status,
    input  logic                     cfg_we,
    input  logic [CAP_W-1:0]         cfg_data,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [DATA_W-1:0] push_value,
    output logic signed [DATA_W-1:0] pop_value,
    output logic [STS_W-1:0]         status,
    output logic [OCC_W-1:0]         occupancy
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int SUM_W = ((PTR_W > OCC_W) ? PTR_W : OCC_W) + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

    logic [CAP_W-1:0]  capacity_reg;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [OCC_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] pop_value_reg;
    logic [STS_W-1:0]  status_reg;
    logic [OCC_W-1:0]  occupancy_reg;

    logic [OCC_W-1:0]  eff_cap;
    logic              is_push, is_full, is_empty;
    logic [STS_W-1:0]  req_status;
    logic [PTR_W-1:0]  head_dec, head_inc;
    logic [PTR_W-1:0]  back_wr_addr, back_rd_addr;
    logic [SUM_W-1:0]  sum_wr, sum_rd;
    logic              ram_we, ram_re;
    logic [PTR_W-1:0]  ram_wr_addr, ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;

    // Clamp capacity to 1..DEPTH
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = OCC_W'(1);
        end
        else if (SUM_W'(capacity_reg) > DEPTH_S)
        begin
            eff_cap = OCC_W'(DEPTH);
        end
        else
        begin
            eff_cap = capacity_reg;
        end
    end

    // Decode the request
    assign is_push  = (cmd == CMD_PUSH_BACK) || (cmd == CMD_PUSH_FRONT);
    assign is_full  = (count_reg >= eff_cap);
    assign is_empty = (count_reg == '0);
    assign dp_status.needs_read = !is_push && !is_empty;

    always_comb
    begin
        if (is_push)
        begin
            req_status = is_full ? STS_FULL : STS_OK;
        end
        else
        begin
            req_status = is_empty ? STS_EMPTY : STS_OK;
        end
    end

    // Circular pointer arithmetic modulo DEPTH
    assign head_dec = (head_reg == '0) ? LAST_P : head_reg - PTR_W'(1);
    assign head_inc = (head_reg == LAST_P) ? '0 : head_reg + PTR_W'(1);

    assign sum_wr = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign sum_rd = SUM_W'(head_reg) + SUM_W'(count_reg) - SUM_W'(1);
    assign back_wr_addr = (sum_wr >= DEPTH_S) ? PTR_W'(sum_wr - DEPTH_S) : PTR_W'(sum_wr);
    assign back_rd_addr = (sum_rd >= DEPTH_S) ? PTR_W'(sum_rd - DEPTH_S) : PTR_W'(sum_rd);

    // Storage access and pointer update for an accepted request
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_wr_addr = back_wr_addr;
        ram_rd_addr = head_reg;
        if (dp_cmd.accept)
        begin
            case (cmd)
                CMD_PUSH_BACK:
                begin
                    if (!is_full)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + OCC_W'(1);
                    end
                end
                CMD_PUSH_FRONT:
                begin
                    ram_wr_addr = head_dec;
                    if (!is_full)
                    begin
                        ram_we     = 1'b1;
                        head_next  = head_dec;
                        count_next = count_reg + OCC_W'(1);
                    end
                end
                CMD_POP_BACK:
                begin
                    ram_rd_addr = back_rd_addr;
                    if (!is_empty)
                    begin
                        ram_re     = 1'b1;
                        count_next = count_reg - OCC_W'(1);
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (!is_empty)
                    begin
                        ram_re     = 1'b1;
                        head_next  = head_inc;
                        count_next = count_reg - OCC_W'(1);
                    end
                end
                default:
                begin
                    head_next = head_reg;
                end
            endcase
        end
    end

    // Control state: capacity, head and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            head_reg     <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_now)
        begin
            pop_value_reg <= '0;
            status_reg    <= req_status;
            occupancy_reg <= count_next;
        end
        else if (dp_cmd.load_ram)
        begin
            pop_value_reg <= ram_rd_data;
            status_reg    <= STS_OK;
            occupancy_reg <= count_reg;
        end
    end

    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (DATA_W'(push_value)),
        .rd_en   (ram_re),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign pop_value = signed'(pop_value_reg);
    assign status    = status_reg;
    assign occupancy = occupancy_reg;

endmodule

### rtl/bounded_deque.sv
`timescale 1ns / 1ps
// Top level of the bounded double-ended queue.
//
//  channel   direction  handshake         payload
//  request   in         in_valid/in_stall cmd, push_value
//  result    out        out_valid/out_stall pop_value, status, occupancy
//  config    in         cfg_valid/cfg_ready cfg_data (capacity)
//
// A push, or a pop that finds the deque empty, loads its result at once
// and the next request can follow. A pop that removes an entry passes
// through S_READ, set by the registered read port of the storage RAM.
// Reset clears head, count and the result valid, and sets capacity to 16.
// A request is taken while a result waits only if that result leaves in the
// same cycle; a stalled result holds its payload.
module bounded_deque
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [DATA_W-1:0] push_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] pop_value,
    output logic [STS_W-1:0]         status,
    output logic [OCC_W-1:0]         occupancy,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CAP_W-1:0]         cfg_data
);

    bdq_cmd_t    dp_cmd;
    bdq_status_t dp_status;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    bdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .dp_status  (dp_status),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .push_value (push_value),
        .pop_value  (pop_value),
        .status     (status),
        .occupancy  (occupancy)
    );

endmodule
